/* rtl/core/btbd_pkg.sv */
// ----------------------------------------------------------------------------
// BCn block decoder package
// Shared widths, payload types and code points for the texture block decoder.
// ----------------------------------------------------------------------------
package btbd_pkg;

   localparam int HALF_W             = 64;
   localparam int BLOCK_W            = 10;
   localparam int PIXEL_W            = 12;
   localparam int SIDE_W             = 13;
   localparam int CHAN_W             = 8;
   localparam int MAX_IMAGE_SIDE_DEF = 4096;

   typedef logic [CHAN_W-1:0]  chan_type;
   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [SIDE_W-1:0]  side_type;
   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [HALF_W-1:0]  half_type;
   typedef logic [1:0]         fmt_type;
   typedef logic [1:0]         csr_index_type;
   typedef logic [SIDE_W-1:0]  csr_data_type;

   // Block format codes.
   localparam fmt_type FMT_BC1  = 2'd0;
   localparam fmt_type FMT_BC2  = 2'd1;
   localparam fmt_type FMT_BC3  = 2'd2;
   localparam fmt_type FMT_NONE = 2'd3;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_FORMAT = 2'd0;
   localparam csr_index_type CSR_WIDTH  = 2'd1;
   localparam csr_index_type CSR_HEIGHT = 2'd2;

endpackage

/* rtl/core/bcn_texture_block_decoder.sv */
// A block's first texel beat passes stage 1, stage 2, the emitter and the output register.
// Throughput: one texel beat per cycle unless the result port stalls. A block holds the texel
// emitter until its texels inside the image (16 for an interior block) are out, which sets
// the block rate. A block with no visible texels is dropped at the second stage.
// Reset (synchronous, active high) empties every stage and sets format BC1 and full size.
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 texture block decoder
// Decodes one compressed 4x4 block into raster-ordered RGBA texels with
// image coordinates, skipping texels outside the configured image size.
// ----------------------------------------------------------------------------
module bcn_texture_block_decoder #(
   parameter int MAX_IMAGE_SIDE = btbd_pkg::MAX_IMAGE_SIDE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  btbd_pkg::half_type      req_color_half,
   input  btbd_pkg::half_type      req_alpha_half,
   input  btbd_pkg::block_type     req_block_col,
   input  btbd_pkg::block_type     req_block_row,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output btbd_pkg::chan_type      rsp_red,
   output btbd_pkg::chan_type      rsp_green,
   output btbd_pkg::chan_type      rsp_blue,
   output btbd_pkg::chan_type      rsp_alpha,
   output btbd_pkg::pixel_type     rsp_pixel_x,
   output btbd_pkg::pixel_type     rsp_pixel_y,
   output logic                    rsp_last_texel,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  btbd_pkg::csr_index_type csr_index,
   input  btbd_pkg::csr_data_type  csr_wdata
);
   import btbd_pkg::*;

   // The image size registers are 13 bits wide. When the side limit does not fit, no
   // programmable size can exceed it, so the limit saturates at the register maximum.
   localparam int       SIDE_CAP   = (1 << SIDE_W) - 1;
   localparam side_type SIDE_LIMIT = (MAX_IMAGE_SIDE > SIDE_CAP) ? side_type'(SIDE_CAP)
                                                                 : side_type'(MAX_IMAGE_SIDE);

   // Stage 1 holds the raw block together with a snapshot of the configuration.
   typedef struct packed {
      half_type  color;
      half_type  alpha;
      block_type col;
      block_type row;
      fmt_type   fmt;
      side_type  w;
      side_type  h;
   } s1_type;

   // Stage 2 holds expanded endpoints and the weighted sums that still need dividing,
   // plus the visible rectangle of the block.
   typedef struct packed {
      chan_type [1:0][2:0] ep;
      logic [2:0][9:0]     sum21;
      logic [2:0][9:0]     sum12;
      logic [2:0][8:0]     sum11;
      logic                four_color;
      chan_type            a0;
      chan_type            a1;
      logic                a_gt;
      logic [5:0][10:0]    as7;
      logic [3:0][10:0]    as5;
      logic [31:0]         cidx;
      half_type            ahalf;
      block_type           col;
      block_type           row;
      fmt_type             fmt;
      logic [1:0]          last_col;
      logic [1:0]          last_row;
      logic                empty;
   } s2_type;

   // The emitter holds the finished palettes and walks the visible texels.
   typedef struct packed {
      chan_type [3:0][2:0] pal_rgb;
      chan_type [3:0]      pal_a;
      chan_type [7:0]      av;
      logic [31:0]         cidx;
      half_type            ahalf;
      block_type           col;
      block_type           row;
      fmt_type             fmt;
      logic [1:0]          last_col;
      logic [1:0]          last_row;
   } em_type;

   typedef struct packed {
      chan_type  r;
      chan_type  g;
      chan_type  b;
      chan_type  a;
      pixel_type x;
      pixel_type y;
      logic      last;
   } out_type;

   // Truncating divides by constants through a scaled reciprocal. The scale factors
   // keep the error below the smallest fractional gap over each input range.
   function automatic chan_type div3(input logic [9:0] v);
      logic [19:0] p;
      p = 20'(v) * 20'd683;
      return p[18:11];
   endfunction

   function automatic chan_type div5(input logic [10:0] v);
      logic [22:0] p;
      p = 23'(v) * 23'd3277;
      return p[21:14];
   endfunction

   function automatic chan_type div7(input logic [10:0] v);
      logic [22:0] p;
      p = 23'(v) * 23'd2341;
      return p[21:14];
   endfunction

   // Configuration registers.
   fmt_type  fmt_ff, fmt_in;
   side_type width_ff, width_in;
   side_type height_ff, height_in;

   // Pipeline registers with their valid bits.
   logic       s1_valid_ff, s1_valid_in;
   s1_type     s1_ff, s1_in;
   logic       s2_valid_ff, s2_valid_in;
   s2_type     s2_ff, s2_in;
   logic       em_valid_ff, em_valid_in;
   em_type     em_ff, em_in;
   logic [1:0] em_col_ff, em_col_in;
   logic [1:0] em_row_ff, em_row_in;
   logic       out_valid_ff, out_valid_in;
   out_type    out_ff, out_in;

   // Flow control.
   logic req_fire, s1_go, s2_ready, s2_go, em_load, em_free, em_fire, out_free, at_last;

   // Stage 1 to stage 2 work.
   s2_type     s2_calc;
   logic [15:0] c0, c1;
   logic [12:0] org_x, org_y, rem_x, rem_y;

   // Stage 2 to emitter work.
   em_type em_calc;

   // Texel selection inside the emitter.
   logic [3:0] tsel;
   logic [1:0] ci;
   logic [5:0] apos;
   logic [2:0] ai;
   logic [3:0] nib;
   out_type    texel;

   // ---------------------------------------------------------------------------
   // Handshake chain. Each stage moves when the stage after it can take the
   // block, so a stall at the result port backs up without loss or repetition.
   // The output register drives the result port; the emitter advances in every
   // cycle in which that register is empty or its beat is being taken.
   // ---------------------------------------------------------------------------
   always_comb begin
      at_last   = (em_col_ff == em_ff.last_col) && (em_row_ff == em_ff.last_row);
      out_free  = !out_valid_ff || rsp_ready;
      em_fire   = em_valid_ff && out_free;
      em_free   = !em_valid_ff || (em_fire && at_last);
      // A block with nothing visible never occupies the emitter.
      s2_go     = s2_valid_ff && (s2_ff.empty || em_free);
      em_load   = s2_valid_ff && !s2_ff.empty && em_free;
      s2_ready  = !s2_valid_ff || s2_go;
      s1_go     = s1_valid_ff && s2_ready;
      req_ready = !s1_valid_ff || s2_ready;
      req_fire  = req_valid && req_ready;
   end

   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------------
   // Configuration writes. Index three has no register and is ignored.
   // ---------------------------------------------------------------------------
   always_comb begin
      fmt_in    = fmt_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FORMAT: begin
               fmt_in = csr_wdata[1:0];
            end
            CSR_WIDTH: begin
               width_in = csr_wdata;
            end
            CSR_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1 capture. The image size is clamped here once per block.
   // ---------------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_in.color = req_color_half;
         s1_in.alpha = req_alpha_half;
         s1_in.col   = req_block_col;
         s1_in.row   = req_block_row;
         s1_in.fmt   = fmt_ff;
         s1_in.w     = (width_ff > SIDE_LIMIT) ? SIDE_LIMIT : width_ff;
         s1_in.h     = (height_ff > SIDE_LIMIT) ? SIDE_LIMIT : height_ff;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1 to 2: RGB565 expansion by bit replication, the weighted endpoint
   // sums for both palette modes, both sets of alpha sums and the visible part
   // of the block. The block origin is the block index times four, so the
   // bounds test needs no adder on the origin itself.
   // ---------------------------------------------------------------------------
   always_comb begin
      c0 = s1_ff.color[15:0];
      c1 = s1_ff.color[31:16];
      s2_calc = '0;
      s2_calc.ep[0][0] = {c0[15:11], c0[15:13]};
      s2_calc.ep[0][1] = {c0[10:5],  c0[10:9]};
      s2_calc.ep[0][2] = {c0[4:0],   c0[4:2]};
      s2_calc.ep[1][0] = {c1[15:11], c1[15:13]};
      s2_calc.ep[1][1] = {c1[10:5],  c1[10:9]};
      s2_calc.ep[1][2] = {c1[4:0],   c1[4:2]};
      for (int k = 0; k < 3; k++) begin
         s2_calc.sum21[k] = 10'({s2_calc.ep[0][k], 1'b0}) + 10'(s2_calc.ep[1][k]);
         s2_calc.sum12[k] = 10'(s2_calc.ep[0][k]) + 10'({s2_calc.ep[1][k], 1'b0});
         s2_calc.sum11[k] = 9'(s2_calc.ep[0][k]) + 9'(s2_calc.ep[1][k]);
      end
      // Only BC1 has the three-color mode with transparent black.
      s2_calc.four_color = (s1_ff.fmt != FMT_BC1) || (c0 > c1);
      s2_calc.a0   = s1_ff.alpha[7:0];
      s2_calc.a1   = s1_ff.alpha[15:8];
      s2_calc.a_gt = s2_calc.a0 > s2_calc.a1;
      for (int i = 0; i < 6; i++) begin
         s2_calc.as7[i] = 11'((6 - i) * s2_calc.a0) + 11'((1 + i) * s2_calc.a1);
      end
      for (int i = 0; i < 4; i++) begin
         s2_calc.as5[i] = 11'((4 - i) * s2_calc.a0) + 11'((1 + i) * s2_calc.a1);
      end
      s2_calc.cidx  = s1_ff.color[63:32];
      s2_calc.ahalf = s1_ff.alpha;
      s2_calc.col   = s1_ff.col;
      s2_calc.row   = s1_ff.row;
      s2_calc.fmt   = s1_ff.fmt;
      org_x = {1'b0, s1_ff.col, 2'b00};
      org_y = {1'b0, s1_ff.row, 2'b00};
      rem_x = s1_ff.w - org_x;
      rem_y = s1_ff.h - org_y;
      // An unknown format and a block wholly outside the image both emit nothing.
      s2_calc.empty = (s1_ff.fmt == FMT_NONE) || (org_x >= s1_ff.w) || (org_y >= s1_ff.h);
      s2_calc.last_col = (rem_x > 13'd3) ? 2'd3 : (rem_x[1:0] - 2'd1);
      s2_calc.last_row = (rem_y > 13'd3) ? 2'd3 : (rem_y[1:0] - 2'd1);
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_in       = s2_ff;
      if (s1_go) begin
         s2_valid_in = 1'b1;
         s2_in       = s2_calc;
      end else if (s2_go) begin
         s2_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2 to emitter: the divides that finish both palettes.
   // ---------------------------------------------------------------------------
   always_comb begin
      em_calc = '0;
      em_calc.pal_rgb[0] = s2_ff.ep[0];
      em_calc.pal_rgb[1] = s2_ff.ep[1];
      em_calc.pal_a[0]   = 8'hFF;
      em_calc.pal_a[1]   = 8'hFF;
      em_calc.pal_a[2]   = 8'hFF;
      if (s2_ff.four_color) begin
         for (int k = 0; k < 3; k++) begin
            em_calc.pal_rgb[2][k] = div3(s2_ff.sum21[k]);
            em_calc.pal_rgb[3][k] = div3(s2_ff.sum12[k]);
         end
         em_calc.pal_a[3] = 8'hFF;
      end else begin
         for (int k = 0; k < 3; k++) begin
            em_calc.pal_rgb[2][k] = s2_ff.sum11[k][8:1];
            em_calc.pal_rgb[3][k] = 8'h00;
         end
         em_calc.pal_a[3] = 8'h00;
      end
      em_calc.av[0] = s2_ff.a0;
      em_calc.av[1] = s2_ff.a1;
      if (s2_ff.a_gt) begin
         for (int i = 0; i < 6; i++) begin
            em_calc.av[2 + i] = div7(s2_ff.as7[i]);
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            em_calc.av[2 + i] = div5(s2_ff.as5[i]);
         end
         em_calc.av[6] = 8'h00;
         em_calc.av[7] = 8'hFF;
      end
      em_calc.cidx     = s2_ff.cidx;
      em_calc.ahalf    = s2_ff.ahalf;
      em_calc.col      = s2_ff.col;
      em_calc.row      = s2_ff.row;
      em_calc.fmt      = s2_ff.fmt;
      em_calc.last_col = s2_ff.last_col;
      em_calc.last_row = s2_ff.last_row;
   end

   // ---------------------------------------------------------------------------
   // Texel emitter. It walks only the visible rectangle in raster order, one texel
   // per cycle unless the output stalls, so the final texel it sends is marked last.
   // ---------------------------------------------------------------------------
   always_comb begin
      tsel = {em_row_ff, em_col_ff};
      ci   = em_ff.cidx[{tsel, 1'b0} +: 2];
      nib  = em_ff.ahalf[{tsel, 2'b00} +: 4];
      apos = 6'd16 + 6'(tsel) * 6'd3;
      ai   = em_ff.ahalf[apos +: 3];
      texel.r = em_ff.pal_rgb[ci][0];
      texel.g = em_ff.pal_rgb[ci][1];
      texel.b = em_ff.pal_rgb[ci][2];
      case (em_ff.fmt)
         FMT_BC2: begin
            texel.a = {nib, nib};
         end
         FMT_BC3: begin
            texel.a = em_ff.av[ai];
         end
         default: begin
            texel.a = em_ff.pal_a[ci];
         end
      endcase
      texel.x    = {em_ff.col, em_col_ff};
      texel.y    = {em_ff.row, em_row_ff};
      texel.last = at_last;
   end

   always_comb begin
      em_valid_in = em_valid_ff;
      em_in       = em_ff;
      em_col_in   = em_col_ff;
      em_row_in   = em_row_ff;
      if (em_load) begin
         em_valid_in = 1'b1;
         em_in       = em_calc;
         em_col_in   = 2'd0;
         em_row_in   = 2'd0;
      end else if (em_fire) begin
         if (at_last) begin
            em_valid_in = 1'b0;
         end else if (em_col_ff == em_ff.last_col) begin
            em_col_in = 2'd0;
            em_row_in = em_row_ff + 2'd1;
         end else begin
            em_col_in = em_col_ff + 2'd1;
         end
      end
   end

   // Output register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (em_fire) begin
         out_valid_in = 1'b1;
         out_in       = texel;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state resets; payload registers load only under a valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= FMT_BC1;
         width_ff     <= SIDE_LIMIT;
         height_ff    <= SIDE_LIMIT;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         em_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         em_valid_ff  <= em_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff     <= s1_in;
      s2_ff     <= s2_in;
      em_ff     <= em_in;
      em_col_ff <= em_col_in;
      em_row_ff <= em_row_in;
      out_ff    <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_red        = out_ff.r;
   assign rsp_green      = out_ff.g;
   assign rsp_blue       = out_ff.b;
   assign rsp_alpha      = out_ff.a;
   assign rsp_pixel_x    = out_ff.x;
   assign rsp_pixel_y    = out_ff.y;
   assign rsp_last_texel = out_ff.last;

endmodule

/* rtl/core/btbd_port_checker.sv */
// ----------------------------------------------------------------------------
// BCn block decoder port checker
// Watches the result port for reset behavior, stall stability and raster order.
// ----------------------------------------------------------------------------
module btbd_port_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input btbd_pkg::chan_type  rsp_red,
   input btbd_pkg::chan_type  rsp_green,
   input btbd_pkg::chan_type  rsp_blue,
   input btbd_pkg::chan_type  rsp_alpha,
   input btbd_pkg::pixel_type rsp_pixel_x,
   input btbd_pkg::pixel_type rsp_pixel_y,
   input logic                rsp_last_texel
);
   import btbd_pkg::*;

   // Coordinates of the previous beat and whether its block is still open.
   pixel_type prev_x_ff, prev_x_in;
   pixel_type prev_y_ff, prev_y_in;
   logic      open_ff, open_in;
   logic      beat;

   always_comb begin
      beat      = rsp_valid && rsp_ready;
      prev_x_in = beat ? rsp_pixel_x : prev_x_ff;
      prev_y_in = beat ? rsp_pixel_y : prev_y_ff;
      open_in   = beat ? !rsp_last_texel : open_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_x_ff <= prev_x_in;
      prev_y_ff <= prev_y_in;
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel_x) &&
         $stable(rsp_pixel_y) && $stable(rsp_red) && $stable(rsp_green) &&
         $stable(rsp_blue) && $stable(rsp_alpha) && $stable(rsp_last_texel)))
      else $error("stalled result beat changed");

   // Texels of one block stay inside the same 4x4 tile until the last one.
   a_same_tile: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && open_ff) |-> (rsp_pixel_x[11:2] == prev_x_ff[11:2] &&
         rsp_pixel_y[11:2] == prev_y_ff[11:2]))
      else $error("texel left its block before the last texel");

   // Within a block the texels advance along a row or start the next row.
   a_raster: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && open_ff) |->
         ((rsp_pixel_y == prev_y_ff && rsp_pixel_x == 12'(prev_x_ff + 12'd1)) ||
          (rsp_pixel_y == 12'(prev_y_ff + 12'd1) && rsp_pixel_x[1:0] == 2'b00)))
      else $error("texels out of raster order");

endmodule

bind bcn_texture_block_decoder btbd_port_checker u_port_checker (.*);

/* tb/sv/texel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texel checker for the BCn block decoder
// Watches the block, texel and register channels, decodes every accepted
// block on its own and compares each texel beat against the oldest texel
// still owed.
// ----------------------------------------------------------------------------
module texel_checker
   import btbd_pkg::*;
#(
   parameter int MAX_SIDE = MAX_IMAGE_SIDE_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_ready,
   input  half_type      req_color_half,
   input  half_type      req_alpha_half,
   input  block_type     req_block_col,
   input  block_type     req_block_row,
   input  logic          rsp_valid,
   input  logic          rsp_ready,
   input  chan_type      rsp_red,
   input  chan_type      rsp_green,
   input  chan_type      rsp_blue,
   input  chan_type      rsp_alpha,
   input  pixel_type     rsp_pixel_x,
   input  pixel_type     rsp_pixel_y,
   input  logic          rsp_last_texel,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wdata,
   output int            mismatches,
   output int            blocks_taken,
   output int            texels_owed,
   output int            texels_seen
);

   typedef struct packed {
      chan_type  red;
      chan_type  green;
      chan_type  blue;
      chan_type  alpha;
      pixel_type px;
      pixel_type py;
      logic      is_last;
   } texel_type;

   fmt_type   cur_format;
   side_type  cur_width;
   side_type  cur_height;
   texel_type expected_texels [$];
   int        bad_count;
   int        block_count;
   int        texel_count;

   // RGB565 to RGB888 by replicating the top bits into the low bits.
   function automatic logic [23:0] widen565(logic [15:0] c);
      return {c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]};
   endfunction

   function automatic void decode_block(half_type color, half_type alph,
                                        block_type col, block_type row);
      int unsigned pal [4][4];
      int unsigned alpha_steps [8];
      texel_type   found [16];
      logic [23:0] rgb0, rgb1;
      int unsigned wide, tall, a0, a1, x, y, ci, kept;
      if (cur_format == FMT_NONE) return;
      wide = (cur_width  > MAX_SIDE) ? MAX_SIDE : cur_width;
      tall = (cur_height > MAX_SIDE) ? MAX_SIDE : cur_height;
      rgb0 = widen565(color[15:0]);
      rgb1 = widen565(color[31:16]);
      for (int k = 0; k < 3; k++) begin
         pal[0][k] = rgb0[23 - 8*k -: 8];
         pal[1][k] = rgb1[23 - 8*k -: 8];
      end
      pal[0][3] = 255;
      pal[1][3] = 255;
      pal[2][3] = 255;
      // Only BC1 with c0 <= c1 drops to three colors plus transparent black.
      if (cur_format != FMT_BC1 || color[15:0] > color[31:16]) begin
         for (int k = 0; k < 3; k++) begin
            pal[2][k] = (2 * pal[0][k] + pal[1][k]) / 3;
            pal[3][k] = (pal[0][k] + 2 * pal[1][k]) / 3;
         end
         pal[3][3] = 255;
      end else begin
         for (int k = 0; k < 3; k++) begin
            pal[2][k] = (pal[0][k] + pal[1][k]) / 2;
            pal[3][k] = 0;
         end
         pal[3][3] = 0;
      end
      a0 = alph[7:0];
      a1 = alph[15:8];
      alpha_steps[0] = a0;
      alpha_steps[1] = a1;
      if (a0 > a1) begin
         for (int i = 0; i < 6; i++)
            alpha_steps[2 + i] = ((6 - i) * a0 + (1 + i) * a1) / 7;
      end else begin
         for (int i = 0; i < 4; i++)
            alpha_steps[2 + i] = ((4 - i) * a0 + (1 + i) * a1) / 5;
         alpha_steps[6] = 0;
         alpha_steps[7] = 255;
      end
      kept = 0;
      for (int t = 0; t < 16; t++) begin
         x = 4 * col + t % 4;
         y = 4 * row + t / 4;
         if (x >= wide || y >= tall) continue;
         ci = color[32 + 2*t +: 2];
         found[kept].red   = chan_type'(pal[ci][0]);
         found[kept].green = chan_type'(pal[ci][1]);
         found[kept].blue  = chan_type'(pal[ci][2]);
         case (cur_format)
            FMT_BC2: found[kept].alpha = {alph[4*t +: 4], alph[4*t +: 4]};
            FMT_BC3: found[kept].alpha = chan_type'(alpha_steps[alph[16 + 3*t +: 3]]);
            default: found[kept].alpha = chan_type'(pal[ci][3]);
         endcase
         found[kept].px      = pixel_type'(x);
         found[kept].py      = pixel_type'(y);
         found[kept].is_last = 1'b0;
         kept++;
      end
      if (kept > 0) found[kept - 1].is_last = 1'b1;
      for (int k = 0; k < kept; k++) expected_texels.push_back(found[k]);
   endfunction

   always @(posedge clock) begin : watch
      texel_type got, want;
      if (reset) begin
         cur_format  = FMT_BC1;
         cur_width   = side_type'(MAX_SIDE);
         cur_height  = side_type'(MAX_SIDE);
         expected_texels.delete();
         bad_count   = 0;
         block_count = 0;
         texel_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FORMAT: cur_format = csr_wdata[1:0];
               CSR_WIDTH:  cur_width  = csr_wdata;
               CSR_HEIGHT: cur_height = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_red, rsp_green, rsp_blue, rsp_alpha,
                    rsp_pixel_x, rsp_pixel_y, rsp_last_texel};
            texel_count++;
            if (expected_texels.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("%0t: texel beat at (%0d,%0d) with no texel owed",
                           $realtime, got.px, got.py);
            end else begin
               want = expected_texels.pop_front();
               if (got !== want) begin
                  bad_count++;
                  if (bad_count <= 10)
                     $display({"%0t: texel mismatch, expected rgba %h %h %h %h ",
                               "xy (%0d,%0d) last %b, got rgba %h %h %h %h ",
                               "xy (%0d,%0d) last %b"}, $realtime,
                              want.red, want.green, want.blue, want.alpha,
                              want.px, want.py, want.is_last,
                              got.red, got.green, got.blue, got.alpha,
                              got.px, got.py, got.is_last);
               end
            end
         end
         if (req_valid && req_ready) begin
            decode_block(req_color_half, req_alpha_half, req_block_col, req_block_row);
            block_count++;
         end
      end
      mismatches   <= bad_count;
      blocks_taken <= block_count;
      texels_owed  <= expected_texels.size();
      texels_seen  <= texel_count;
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCn block decoder testbench
// Drives compressed blocks and register writes into the decoder, pulls the
// texel stream with random back-pressure and leaves the checking to the
// texel checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb;
   import btbd_pkg::*;

   // A block with no visible texels still passes through stage 1 and stage 2
   // before it leaves the pipe; the drain wait lets it out before the registers
   // may change.
   localparam int DRAIN_CYCLES     = 8;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES    = 6;
   localparam int BLOCKS_PER_PHASE = 16;
   // The slowest correct run is far below a tenth of this.
   localparam int LIMIT_CYCLES     = 2_000_000;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   half_type      req_color_half;
   half_type      req_alpha_half;
   block_type     req_block_col;
   block_type     req_block_row;
   logic          rsp_valid;
   logic          rsp_ready;
   chan_type      rsp_red;
   chan_type      rsp_green;
   chan_type      rsp_blue;
   chan_type      rsp_alpha;
   pixel_type     rsp_pixel_x;
   pixel_type     rsp_pixel_y;
   logic          rsp_last_texel;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   int mismatches;
   int blocks_taken;
   int texels_owed;
   int texels_seen;

   // Stimulus knobs for the sender and the texel sink, and run counters.
   bit req_pauses;
   bit rsp_stalls;
   bit long_hold;
   int blocks_sent;
   int settings_used;

   bcn_texture_block_decoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_color_half (req_color_half),
      .req_alpha_half (req_alpha_half),
      .req_block_col  (req_block_col),
      .req_block_row  (req_block_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_texel (rsp_last_texel),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   texel_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_color_half (req_color_half),
      .req_alpha_half (req_alpha_half),
      .req_block_col  (req_block_col),
      .req_block_row  (req_block_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_texel (rsp_last_texel),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .blocks_taken   (blocks_taken),
      .texels_owed    (texels_owed),
      .texels_seen    (texels_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Gap length in cycles: usually from a short range, one draw in ten from a long range.
   function automatic int pause_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Image sides mix in small images, so that the clipping at the right and bottom
   // edges is hit often, with zero, oversized and random values; full size is the most common.
   function automatic side_type pick_side();
      case ($urandom_range(0, 7))
         0:       return side_type'(0);
         1:       return side_type'(13'h1FFF);
         2, 3:    return side_type'($urandom_range(1, 40));
         4:       return side_type'($urandom_range(1, 8191));
         default: return side_type'(MAX_IMAGE_SIDE_DEF);
      endcase
   endfunction

   // Waits until every accepted block has been decoded and every owed texel
   // has come out, then lets a block without visible texels leave the pipe.
   task automatic settle();
      req_valid <= 1'b0;
      while (blocks_taken != blocks_sent || texels_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers in one burst while the decoder is idle. The
   // valid stays high across the three beats.
   task automatic set_image(fmt_type fmt, side_type wide, side_type tall);
      csr_index_type regs [3];
      csr_data_type  vals [3];
      settle();
      regs = '{CSR_FORMAT, CSR_WIDTH, CSR_HEIGHT};
      vals = '{csr_data_type'(fmt), wide, tall};
      for (int r = 0; r < 3; r++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[r];
         csr_wdata <= vals[r];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Offers one block and waits for its beat. Valid only drops when a gap
   // follows; otherwise the next block goes out right behind this one.
   task automatic send_block(half_type color, half_type alph, block_type col,
                             block_type row);
      int gap;
      req_valid      <= 1'b1;
      req_color_half <= color;
      req_alpha_half <= alph;
      req_block_col  <= col;
      req_block_row  <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      blocks_sent++;
      gap = (req_pauses && $urandom_range(0, 2) == 0) ? pause_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Texel sink. It decides once per cycle; a stall or the long hold keeps
   // ready low for a run of cycles counted here.
   initial begin : texel_sink
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (rsp_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (pause_len() - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 12);
      $display("tb failed");
      $finish;
   end

   initial begin : stimulus
      fmt_type   rnd_fmt;
      side_type  rnd_w, rnd_h;
      block_type col, row;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_color_half <= '0;
      req_alpha_half <= '0;
      req_block_col  <= '0;
      req_block_row  <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_FORMAT;
      csr_wdata      <= '0;
      req_pauses     = 1'b0;
      rsp_stalls     = 1'b0;
      long_hold      = 1'b0;
      blocks_sent    = 0;
      settings_used  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, BC1 at full size, no idling. Four-color mode with
      // c0 > c1, three-color mode with c0 < c1 and c0 == c1 (index three is
      // transparent black), all-zero and all-one blocks and the far corner
      // of the largest image.
      send_block({32'h1B1B_E4E4, 16'h1234, 16'hF800}, 64'h0, 10'd0, 10'd0);
      send_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, {2{32'hA5A5_5A5A}},
                 10'd1023, 10'd1023);
      send_block({32'hFFFF_FFFF, 16'h07E0, 16'h07E0}, '1, 10'd5, 10'd7);
      send_block(64'h0, '1, 10'd0, 10'd1023);
      send_block('1, 64'h0, 10'd1023, 10'd0);

      // BC2 always has four colors, even with c0 < c1; explicit alpha goes
      // through every nibble value.
      req_pauses = 1'b1;
      rsp_stalls = 1'b1;
      set_image(FMT_BC2, 13'd4096, 13'd4096);
      send_block({32'hE4E4_E4E4, 16'hF81F, 16'h001F}, 64'hFEDC_BA98_7654_3210,
                 10'd0, 10'd0);
      send_block('1, '1, 10'd1023, 10'd0);
      send_block({$urandom, $urandom}, 64'h0, 10'd0, 10'd1023);

      // BC3 on a 6x5 image: eight-value mode, six-value mode with the fixed
      // 0 and 255 entries, equal endpoints, a block cut down to two texels,
      // one cut to a single row and blocks wholly outside the image.
      set_image(FMT_BC3, 13'd6, 13'd5);
      send_block({$urandom, 16'h1234, 16'h5678}, {48'o7654321076543210, 8'h20, 8'hF0},
                 10'd0, 10'd0);
      send_block({$urandom, 16'hFFFF, 16'h0000}, {48'o0123456701234567, 8'hE0, 8'h10},
                 10'd1, 10'd1);
      send_block({$urandom, $urandom}, {48'o7777666655554444, 8'h80, 8'h80},
                 10'd1, 10'd0);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 10'd2, 10'd0);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 10'd0, 10'd2);
      send_block({$urandom, $urandom}, {16'h0000, $urandom, 16'h00FF}, 10'd0, 10'd1);

      // One-pixel image: a single texel that is also the last one.
      set_image(FMT_BC1, 13'd1, 13'd1);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 10'd0, 10'd0);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 10'd0, 10'd1);

      // The unused format code produces nothing at all.
      set_image(FMT_NONE, 13'd4096, 13'd4096);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 10'd0, 10'd0);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 10'd3, 10'd3);

      // A zero side hides everything; sides above the maximum are clamped.
      set_image(FMT_BC3, 13'd0, 13'h1FFF);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 10'd0, 10'd0);
      set_image(FMT_BC2, 13'h1FFF, 13'd4097);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 10'd1023, 10'd1023);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 10'd0, 10'd0);
      set_image(FMT_BC1, 13'd4096, 13'd0);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 10'd0, 10'd0);

      // Random phases. The first one runs at full size without idling and
      // starts with a long hold on the texel side, so the decoder fills up
      // and has to push back on the block channel.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            rnd_fmt = fmt_type'($urandom_range(0, 2));
            rnd_w   = side_type'(MAX_IMAGE_SIDE_DEF);
            rnd_h   = side_type'(MAX_IMAGE_SIDE_DEF);
         end else begin
            rnd_fmt = ($urandom_range(0, 7) == 0) ? FMT_NONE
                                                  : fmt_type'($urandom_range(0, 2));
            rnd_w   = pick_side();
            rnd_h   = pick_side();
         end
         set_image(rnd_fmt, rnd_w, rnd_h);
         req_pauses = (p != 0) && ($urandom_range(0, 3) != 0);
         rsp_stalls = (p != 0) && ($urandom_range(0, 3) != 0);
         long_hold  = (p == 0);
         for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
            // On a small image keep the blocks near its edges.
            col = (rnd_w < 64) ? block_type'($urandom_range(0, rnd_w / 4 + 1))
                               : block_type'($urandom_range(0, 1023));
            row = (rnd_h < 64) ? block_type'($urandom_range(0, rnd_h / 4 + 1))
                               : block_type'($urandom_range(0, 1023));
            send_block({$urandom, $urandom}, {$urandom, $urandom}, col, row);
         end
      end

      settle();
      $display("Run covered %0d blocks and %0d texel beats over %0d register settings,",
               blocks_sent, texels_seen, settings_used);
      $display("with all three formats, the unused code, clipped and clamped image sides.");
      if (mismatches == 0 && texels_owed == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
